// File: design/hacc_pkg.sv
`timescale 1ns / 1ps

package hacc_pkg;

   localparam int BINS        = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int BIN_BITS    = $clog2(BINS);
   localparam int SQ_BITS     = 2 * SAMPLE_BITS;
   localparam int WIDE_BITS   = 18;

   localparam logic signed [15:0] RANGE_MIN_RST = 16'sd0;
   localparam logic signed [15:0] RANGE_MAX_RST = 16'sd255;

   localparam logic CSR_RANGE_MIN = 1'b0;
   localparam logic CSR_RANGE_MAX = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_CONFIG = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_LOOKUP = 2'd1,
      FSM_APPLY  = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic signed [15:0] sample;
      logic [7:0]         bin_index;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        bin_count;
      logic [31:0]        total_count;
      logic signed [47:0] value_sum;
      logic [62:0]        square_sum;
      logic [31:0]        peak_count;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic apply;
   } ctl_type;

endpackage

// File: design/hacc_ctrl.sv
`timescale 1ns / 1ps

module hacc_ctrl
   import hacc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_LOOKUP;
         end
         FSM_LOOKUP: begin
            state_in = FSM_APPLY;
         end
         FSM_APPLY: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         FSM_LOOKUP: begin
            ctl.lookup = 1'b1;
         end
         FSM_APPLY: begin
            ctl.apply = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      rsp_valid_in = ctl.apply || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/hacc_dp.sv
`timescale 1ns / 1ps

module hacc_dp
   import hacc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctl_type      ctl,
   input  req_word_type req_word,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata,
   output rsp_word_type rsp_word
);

   logic [31:0] mem [BINS];

   logic signed [15:0]    range_min_ff, range_max_ff;
   req_word_type          item_ff;
   logic [BINS-1:0]       vld_ff;
   logic [31:0]           total_ff;
   logic signed [47:0]    sum_ff;
   logic [62:0]           sq_sum_ff;
   logic [31:0]           peak_ff;
   rsp_word_type          rsp_ff;

   logic [BIN_BITS-1:0]   addr_ff;
   logic [31:0]           rd_data_ff;
   logic                  hit_ff;
   logic [SQ_BITS-1:0]    sq_ff;
   status_type            status_ff, status_in;

   logic signed [SAMPLE_BITS-1:0] smp;
   logic signed [WIDE_BITS-1:0]   s_wide, min_wide, max_wide, span, off;
   logic [WIDE_BITS-1:0]          idx_wide;
   logic                          range_ok, in_range, read_ok;
   logic [BIN_BITS-1:0]           addr_in;
   logic [SQ_BITS-1:0]            sq_in;

   logic [31:0]        old_cnt, new_cnt;
   logic               do_add, do_clear;
   rsp_word_type       rsp_in;

   // lookup stage
   always_comb begin
      smp      = item_ff.sample[SAMPLE_BITS-1:0];
      s_wide   = WIDE_BITS'(smp);
      min_wide = WIDE_BITS'(range_min_ff);
      max_wide = WIDE_BITS'(range_max_ff);
      span     = max_wide - min_wide;
      off      = s_wide - min_wide;
      range_ok = !span[WIDE_BITS-1] && (span < WIDE_BITS'(BINS));
      in_range = (s_wide >= min_wide) && (s_wide <= max_wide);
      idx_wide = WIDE_BITS'(item_ff.bin_index);
      read_ok  = idx_wide < WIDE_BITS'(BINS);
      sq_in    = SQ_BITS'(smp * smp);
      addr_in  = off[BIN_BITS-1:0];
      status_in = STAT_OK;
      case (item_ff.command)
         CMD_ADD: begin
            if (!range_ok) status_in = STAT_CONFIG;
            else if (!in_range) status_in = STAT_RANGE;
            else if (&total_ff) status_in = STAT_FULL;
         end
         CMD_READ: begin
            addr_in = idx_wide[BIN_BITS-1:0];
            if (!read_ok) status_in = STAT_RANGE;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // apply stage
   always_comb begin
      old_cnt  = hit_ff ? rd_data_ff : 32'd0;
      new_cnt  = old_cnt + 32'd1;
      do_add   = (item_ff.command == CMD_ADD) && (status_ff == STAT_OK);
      do_clear = (item_ff.command == CMD_CLEAR);
      rsp_in.status      = status_ff;
      rsp_in.bin_count   = 32'd0;
      rsp_in.total_count = total_ff;
      rsp_in.value_sum   = sum_ff;
      rsp_in.square_sum  = sq_sum_ff;
      rsp_in.peak_count  = peak_ff;
      case (item_ff.command)
         CMD_CLEAR: begin
            rsp_in.total_count = 32'd0;
            rsp_in.value_sum   = 48'sd0;
            rsp_in.square_sum  = 63'd0;
            rsp_in.peak_count  = 32'd0;
         end
         CMD_ADD: begin
            if (do_add) begin
               rsp_in.bin_count   = new_cnt;
               rsp_in.total_count = total_ff + 32'd1;
               rsp_in.value_sum   = sum_ff + 48'(smp);
               rsp_in.square_sum  = sq_sum_ff + 63'(sq_ff);
               if (new_cnt > peak_ff) rsp_in.peak_count = new_cnt;
            end
         end
         CMD_READ: begin
            if (status_ff == STAT_OK) rsp_in.bin_count = old_cnt;
         end
         default: begin
            rsp_in.bin_count = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) item_ff <= req_word;
      if (ctl.lookup) begin
         addr_ff    <= addr_in;
         rd_data_ff <= mem[addr_in];
         hit_ff     <= vld_ff[addr_in];
         sq_ff      <= sq_in;
         status_ff  <= status_in;
      end
      if (ctl.apply) begin
         rsp_ff <= rsp_in;
         if (do_add) mem[addr_ff] <= new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= RANGE_MIN_RST;
         range_max_ff <= RANGE_MAX_RST;
         vld_ff       <= '0;
         total_ff     <= 32'd0;
         sum_ff       <= 48'sd0;
         sq_sum_ff    <= 63'd0;
         peak_ff      <= 32'd0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_RANGE_MIN) range_min_ff <= csr_wdata;
            if (csr_addr == CSR_RANGE_MAX) range_max_ff <= csr_wdata;
         end
         if (ctl.apply && (do_add || do_clear)) begin
            if (do_clear) vld_ff <= '0;
            else vld_ff[addr_ff] <= 1'b1;
            total_ff  <= rsp_in.total_count;
            sum_ff    <= rsp_in.value_sum;
            sq_sum_ff <= rsp_in.square_sum;
            peak_ff   <= rsp_in.peak_count;
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// File: design/histogram_accumulator_with_stats_core.sv
`timescale 1ns / 1ps

// Histogram engine with running statistics. Each request word (clear, add
// sample, read bin) yields one response word carrying status, the bin count
// and the current total, sum, sum of squares and peak bin count. A word goes
// from acceptance to response through accept, registered bin store read, and
// update and write back, which waits while an earlier response is stalled.
// A new word is taken once the previous one has left the update step,
// even while its response is still stalled. Clear drops all per-bin valid
// flags together, so no clearing pass follows reset. Range registers must
// be written only while the block is idle; the block does not enforce it.
module histogram_accumulator_with_stats_core
   import hacc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);

   ctl_type ctl;

   hacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   hacc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_word)
   );

endmodule

// File: design/hacc_checker.sv
`timescale 1ns / 1ps

module hacc_checker
   import hacc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous word in flight");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STAT_OK) |-> rsp_word.bin_count == 32'd0)
      else $error("refused word reports a bin count");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.bin_count <= rsp_word.peak_count)
      else $error("bin count above peak count");

endmodule

bind histogram_accumulator_with_stats_core hacc_checker u_hacc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// File: tb/sv/histogram_accumulator_with_stats_core_test.sv
`timescale 1ns / 1ps

module histogram_accumulator_with_stats_core_test;
   import hacc_pkg::*;

   localparam cmd_type CMD_SPARE   = cmd_type'(2'd3);
   localparam int      QUIET_LIMIT = 4000;
   localparam int      HOLD_AFTER  = 400;
   localparam int      HOLD_CYCLES = 160;

   typedef struct packed {
      req_word_type word;
      logic         known;
      rsp_word_type result;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we = 1'b0;
   logic         csr_addr = CSR_RANGE_MIN;
   logic [15:0]  csr_wdata = '0;

   logic         req_known = 1'b0;
   rsp_word_type req_known_rsp = '0;

   logic [31:0]        bin_tally [BINS];
   logic [31:0]        tally_total = '0;
   logic signed [47:0] sample_sum = '0;
   logic [62:0]        square_total = '0;
   logic [31:0]        peak_tally = '0;
   logic signed [15:0] range_lo = RANGE_MIN_RST;
   logic signed [15:0] range_hi = RANGE_MAX_RST;

   rsp_word_type pending_stats [$];
   int   sent_words = 0;
   int   accepted_words = 0;
   int   received_words = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   logic steady = 1'b0;

   int   stall_run = 0;
   logic stall_on = 1'b0;
   logic hold_done = 1'b0;

   histogram_accumulator_with_stats_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
   end

   function automatic logic range_ok();
      int lo = range_lo;
      int hi = range_hi;
      return hi >= lo && hi - lo < BINS;
   endfunction

   function automatic rsp_word_type histogram_step(input req_word_type w);
      rsp_word_type r;
      int           s;
      int           lo;
      int           hi;
      int           b;
      r = '0;
      r.status = STAT_OK;
      s = int'($signed(w.sample));
      lo = range_lo;
      hi = range_hi;
      case (w.command)
         CMD_CLEAR: begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            tally_total = '0;
            sample_sum = '0;
            square_total = '0;
            peak_tally = '0;
         end
         CMD_ADD: begin
            if (!range_ok()) begin
               r.status = STAT_CONFIG;
            end else if (s < lo || s > hi) begin
               r.status = STAT_RANGE;
            end else if (tally_total == 32'hFFFF_FFFF) begin
               r.status = STAT_FULL;
            end else begin
               b = s - lo;
               bin_tally[b] = bin_tally[b] + 32'd1;
               r.bin_count = bin_tally[b];
               tally_total = tally_total + 32'd1;
               sample_sum = sample_sum + s;
               square_total = square_total + 63'(longint'(s) * longint'(s));
               if (bin_tally[b] > peak_tally) peak_tally = bin_tally[b];
            end
         end
         CMD_READ: begin
            if (int'(w.bin_index) < BINS) r.bin_count = bin_tally[w.bin_index];
            else r.status = STAT_RANGE;
         end
         default: ;
      endcase
      r.total_count = tally_total;
      r.value_sum = sample_sum;
      r.square_sum = square_total;
      r.peak_count = peak_tally;
      return r;
   endfunction

   function automatic req_word_type make_word(input cmd_type c, input int s, input int idx);
      req_word_type w;
      w.command = c;
      w.sample = 16'(s);
      w.bin_index = 8'(idx);
      return w;
   endfunction

   function automatic rsp_word_type stats(input status_type st, input longint count,
                                          input longint total, input longint sum,
                                          input longint sq, input longint peak);
      rsp_word_type r;
      r.status = st;
      r.bin_count = 32'(count);
      r.total_count = 32'(total);
      r.value_sum = 48'(sum);
      r.square_sum = 63'(sq);
      r.peak_count = 32'(peak);
      return r;
   endfunction

   function automatic stim_row_type make_row(input req_word_type w, input logic known,
                                             input rsp_word_type r);
      stim_row_type row;
      row.word = w;
      row.known = known;
      row.result = r;
      return row;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      int           lo;
      int           span;
      pick = $urandom_range(0, 99);
      lo = range_lo;
      span = range_ok() ? int'(range_hi) - lo : 255;
      w.sample = 16'($urandom);
      w.bin_index = 8'($urandom);
      if (pick < 60) begin
         w.command = CMD_ADD;
         case ($urandom_range(0, 9))
            0: w.sample = 16'(lo - 1);
            1: w.sample = 16'(int'(range_hi) + 1);
            2: ;
            default: w.sample = 16'(lo + $urandom_range(0, span));
         endcase
      end else if (pick < 90) begin
         w.command = CMD_READ;
         if ($urandom_range(0, 1) == 0) w.bin_index = 8'($urandom_range(0, span));
      end else if (pick < 97) begin
         w.command = CMD_SPARE;
      end else begin
         w.command = CMD_CLEAR;
      end
      return w;
   endfunction

   function automatic int idle_cycles();
      int pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 9);
      return $urandom_range(12, 30);
   endfunction

   task automatic send_word(input req_word_type w, input logic known,
                            input rsp_word_type known_rsp);
      int gap;
      gap = steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      req_known <= known;
      req_known_rsp <= known_rsp;
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (received_words != sent_words) @(posedge clock);
   endtask

   task automatic write_ranges(input int lo, input int hi);
      csr_we <= 1'b1;
      csr_addr <= CSR_RANGE_MIN;
      csr_wdata <= 16'(lo);
      @(posedge clock);
      csr_addr <= CSR_RANGE_MAX;
      csr_wdata <= 16'(hi);
      @(posedge clock);
      csr_we <= 1'b0;
      range_lo = 16'(lo);
      range_hi = 16'(hi);
   endtask

   always @(posedge clock) begin
      rsp_word_type model_rsp;
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && req_valid && !req_stall) begin
         model_rsp = histogram_step(req_word);
         pending_stats.push_back(req_known ? req_known_rsp : model_rsp);
         accepted_words++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_word;
         received_words++;
         if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word %0d: status %0d count %0d total %0d",
                        received_words, got.status, got.bin_count, got.total_count);
         end else begin
            want = pending_stats.pop_front();
            if (got.status !== want.status || got.bin_count !== want.bin_count ||
                got.total_count !== want.total_count || got.value_sum !== want.value_sum ||
                got.square_sum !== want.square_sum || got.peak_count !== want.peak_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word %0d expected: status %0d count %0d total %0d sum %0d sq %0d peak %0d",
                           received_words, want.status, want.bin_count, want.total_count,
                           $signed(want.value_sum), want.square_sum, want.peak_count);
                  $display("word %0d actual:   status %0d count %0d total %0d sum %0d sq %0d peak %0d",
                           received_words, got.status, got.bin_count, got.total_count,
                           $signed(got.value_sum), got.square_sum, got.peak_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!hold_done && accepted_words >= HOLD_AFTER) begin
         hold_done = 1'b1;
         stall_on = 1'b1;
         stall_run = HOLD_CYCLES;
      end else if (stall_run <= 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               stall_on = 1'b0;
               stall_run = $urandom_range(1, 30);
            end
            9: begin
               stall_on = 1'b1;
               stall_run = $urandom_range(8, 40);
            end
            default: begin
               stall_on = 1'b1;
               stall_run = $urandom_range(1, 3);
            end
         endcase
      end
      rsp_stall <= stall_on;
      stall_run--;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type directed_rows [$];
      int           phase_lo [9];
      int           phase_hi [9];
      int           item_budget;
      rsp_word_type none;
      none = '0;

      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 0), 1'b1,
                                       stats(STAT_OK, 0, 0, 0, 0, 0)));
      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 255), 1'b1,
                                       stats(STAT_OK, 0, 0, 0, 0, 0)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 0, 0), 1'b1,
                                       stats(STAT_OK, 1, 1, 0, 0, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 255, 0), 1'b1,
                                       stats(STAT_OK, 1, 2, 255, 65025, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, -32768, 0), 1'b1,
                                       stats(STAT_RANGE, 0, 2, 255, 65025, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 32767, 255), 1'b1,
                                       stats(STAT_RANGE, 0, 2, 255, 65025, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, -1, 0), 1'b1,
                                       stats(STAT_RANGE, 0, 2, 255, 65025, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 256, 0), 1'b1,
                                       stats(STAT_RANGE, 0, 2, 255, 65025, 1)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 255, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 255, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_READ, -1, 255), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 1), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_SPARE, -1, 255), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 128, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_CLEAR, 32767, 255), 1'b1,
                                       stats(STAT_OK, 0, 0, 0, 0, 0)));
      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 255), 1'b1,
                                       stats(STAT_OK, 0, 0, 0, 0, 0)));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 1, 0), 1'b1,
                                       stats(STAT_OK, 1, 1, 1, 1, 1)));
      directed_rows.push_back(make_row(make_word(CMD_SPARE, 0, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_ADD, 128, 0), 1'b0, none));
      directed_rows.push_back(make_row(make_word(CMD_READ, 0, 128), 1'b0, none));

      phase_lo = '{-32768, 32512, -128, 7, 100, 0, -32768, 0, 0};
      phase_hi = '{-32513, 32767, 127, 7, -100, 256, 32767, 255, 0};
      phase_lo[8] = int'($urandom_range(0, 65535)) - 32768;
      phase_hi[8] = phase_lo[8] + int'($urandom_range(0, 255));
      if (phase_hi[8] > 32767) phase_hi[8] = 32767;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);

      for (int p = 0; p < 9; p++) begin
         drain_words();
         write_ranges(phase_lo[p], phase_hi[p]);
         steady = ($urandom_range(0, 3) == 0);
         item_budget = range_ok() ? 230 : 80;
         repeat (item_budget) send_word(random_word(), 1'b0, none);
      end

      drain_words();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_stats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
